FILE: design/srtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types, constants and helpers of the SRTF scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int MAX_JOBS  = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int PID_BITS  = 4;
    localparam int REM_BITS  = 16;
    localparam int OUT_TIME_BITS = 16;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [REM_BITS-1:0]  rem_t;

    localparam time_t TIME_MAX = '1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic  valid;
        logic  found;
        logic  any;
        logic  many;
        logic  disp;
        slot_t id;
        rem_t  rem;
        time_t arr;
        time_t min_arr;
    } tok_t;

    typedef struct packed {
        logic  load_en;
        slot_t load_id;
        time_t load_arr;
        rem_t  load_rem;
        logic  commit_en;
        slot_t commit_id;
    } cmd_t;

    function automatic time_t sat_arrival(input logic [OUT_TIME_BITS-1:0] a);
        time_t r;
        if (32'(a) > 32'(TIME_MAX)) begin
            r = TIME_MAX;
        end else begin
            r = TIME_BITS'(a);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: design/srtf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_cell
// One job slot: holds arrival, remaining work and flags, and merges its
// candidate into the scan token passing along the chain.
// ----------------------------------------------------------------------------
module srtf_cell import srtf_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire slot_t slot_idx,
    input  wire time_t now_time,
    input  wire cmd_t  cmd,
    input  wire tok_t  tok_in,
    output tok_t       tok_out
);

    time_t arr_reg, arr_next;
    rem_t  rem_reg, rem_next;
    logic  live_reg, live_next;
    logic  disp_reg, disp_next;
    tok_t  tok_reg, tok_next;

    logic has_work, eligible, better;

    always_comb begin
        arr_next  = arr_reg;
        rem_next  = rem_reg;
        live_next = live_reg;
        disp_next = disp_reg;
        if (cmd.load_en && cmd.load_id == slot_idx) begin
            arr_next  = cmd.load_arr;
            rem_next  = cmd.load_rem;
            live_next = 1'b1;
            disp_next = 1'b0;
        end else if (cmd.commit_en && cmd.commit_id == slot_idx) begin
            rem_next  = rem_reg - rem_t'(1);
            disp_next = 1'b1;
        end
    end

    always_comb begin
        has_work = live_reg && (rem_reg != '0);
        eligible = has_work && (arr_reg <= now_time);
        better   = eligible && (!tok_in.found || (rem_reg < tok_in.rem) ||
                   ((rem_reg == tok_in.rem) && (arr_reg < tok_in.arr)));
        tok_next       = tok_in;
        tok_next.found = tok_in.found | eligible;
        tok_next.any   = tok_in.any | has_work;
        tok_next.many  = tok_in.many | (tok_in.any & has_work);
        if (better) begin
            tok_next.id   = slot_idx;
            tok_next.rem  = rem_reg;
            tok_next.arr  = arr_reg;
            tok_next.disp = disp_reg;
        end
        if (has_work && (!tok_in.any || (arr_reg < tok_in.min_arr))) begin
            tok_next.min_arr = arr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= 1'b0;
            disp_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            live_reg      <= live_next;
            disp_reg      <= disp_next;
            tok_reg.valid <= tok_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        arr_reg       <= arr_next;
        rem_reg       <= rem_next;
        tok_reg.found <= tok_next.found;
        tok_reg.any   <= tok_next.any;
        tok_reg.many  <= tok_next.many;
        tok_reg.disp  <= tok_next.disp;
        tok_reg.id    <= tok_next.id;
        tok_reg.rem   <= tok_next.rem;
        tok_reg.arr   <= tok_next.arr;
        tok_reg.min_arr <= tok_next.min_arr;
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

FILE: design/srtf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: takes transactions, launches scan tokens into the cell chain,
// applies the start-of-run time jump and commits each tick's result.
// ----------------------------------------------------------------------------
module srtf_ctrl import srtf_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_kind,
    input  wire logic [PID_BITS-1:0]      s_process_id,
    input  wire logic [OUT_TIME_BITS-1:0] s_arrival_time,
    input  wire logic [REM_BITS-1:0]      s_burst_time,

    output logic      m_valid,
    input  wire logic m_ready,
    output logic [OUT_TIME_BITS-1:0] m_tick_time,
    output logic [PID_BITS-1:0]      m_running_id,
    output logic      m_idle,
    output logic      m_switched,
    output logic      m_first_run,
    output logic      m_finished,
    output logic      m_all_done,

    output cmd_t      cmd,
    output time_t     now_time,
    output tok_t      tok_first,
    input  wire tok_t tok_last
);

    ctrl_state_t state_reg, state_next;
    logic  run_started_reg, run_started_next;
    logic  jump_reg, jump_next;
    logic  launch_reg, launch_next;
    time_t clock_reg, clock_next;
    logic  last_valid_reg, last_valid_next;
    slot_t last_id_reg, last_id_next;
    tok_t  res_reg;

    logic  m_valid_reg, m_valid_next;
    logic [OUT_TIME_BITS-1:0] m_tick_time_reg;
    logic [PID_BITS-1:0]      m_running_id_reg;
    logic  m_idle_reg, m_switched_reg, m_first_run_reg, m_finished_reg, m_all_done_reg;

    logic accept, tick_fire, load_fire, commit_fire, scan_done, do_jump;
    logic res_finished, res_all_done;

    always_comb begin
        accept    = s_valid && s_ready;
        tick_fire = accept && (s_kind == KIND_TICK);
        load_fire = accept && (s_kind == KIND_LOAD) && (s_burst_time != '0) &&
                    (32'(s_process_id) < 32'(MAX_JOBS));
        do_jump   = (state_reg == ST_SCAN) && tok_last.valid && jump_reg && tok_last.any;
        scan_done = (state_reg == ST_SCAN) && tok_last.valid && !do_jump;
        res_finished = res_reg.found && (res_reg.rem == rem_t'(1));
        res_all_done = !res_reg.any || (!res_reg.many && res_finished);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_fire) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        commit_fire = (state_reg == ST_COMMIT) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        run_started_next = run_started_reg;
        jump_next        = jump_reg;
        launch_next      = 1'b0;
        clock_next       = clock_reg;
        last_valid_next  = last_valid_reg;
        last_id_next     = last_id_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        if (tick_fire) begin
            launch_next      = 1'b1;
            jump_next        = !run_started_reg;
            run_started_next = 1'b1;
        end
        if ((state_reg == ST_SCAN) && tok_last.valid) begin
            jump_next = 1'b0;
        end
        if (do_jump) begin
            clock_next  = tok_last.min_arr;
            launch_next = 1'b1;
        end
        if (commit_fire) begin
            m_valid_next = 1'b1;
            if (clock_reg != TIME_MAX) clock_next = clock_reg + time_t'(1);
            if (!res_reg.found || res_finished) begin
                last_valid_next = 1'b0;
            end else begin
                last_valid_next = 1'b1;
                last_id_next    = res_reg.id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            run_started_reg <= 1'b0;
            jump_reg        <= 1'b0;
            launch_reg      <= 1'b0;
            clock_reg       <= '0;
            last_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            run_started_reg <= run_started_next;
            jump_reg        <= jump_next;
            launch_reg      <= launch_next;
            clock_reg       <= clock_next;
            last_valid_reg  <= last_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_id_reg <= last_id_next;
        if ((state_reg == ST_SCAN) && tok_last.valid) begin
            res_reg <= tok_last;
        end
        if (commit_fire) begin
            m_tick_time_reg  <= OUT_TIME_BITS'(clock_reg);
            m_running_id_reg <= res_reg.found ? PID_BITS'(res_reg.id) : '0;
            m_idle_reg       <= !res_reg.found;
            m_switched_reg   <= res_reg.found &&
                                (!last_valid_reg || (res_reg.id != last_id_reg));
            m_first_run_reg  <= res_reg.found && !res_reg.disp;
            m_finished_reg   <= res_finished;
            m_all_done_reg   <= res_all_done;
        end
    end

    always_comb begin
        cmd.load_en   = load_fire;
        cmd.load_id   = SLOT_BITS'(s_process_id);
        cmd.load_arr  = sat_arrival(s_arrival_time);
        cmd.load_rem  = s_burst_time;
        cmd.commit_en = commit_fire && res_reg.found;
        cmd.commit_id = res_reg.id;
        now_time      = clock_reg;
        tok_first       = '0;
        tok_first.valid = launch_reg;
    end

    assign m_valid      = m_valid_reg;
    assign m_tick_time  = m_tick_time_reg;
    assign m_running_id = m_running_id_reg;
    assign m_idle       = m_idle_reg;
    assign m_switched   = m_switched_reg;
    assign m_first_run  = m_first_run_reg;
    assign m_finished   = m_finished_reg;
    assign m_all_done   = m_all_done_reg;

endmodule
`default_nettype wire

FILE: design/srtf_preemptive_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// Shortest-remaining-time-first scheduler over a chain of job-slot cells.
//
// Input channel s_*: a transaction with s_kind = load writes one job slot
// (arrival, burst) and gives no result; zero bursts and slots
// beyond the table are dropped. A transaction with s_kind = tick runs one
// scheduler step and gives exactly one result on m_*.
// A tick launches a token that walks the MAX_JOBS cells, one cell per cycle,
// picking the least remaining time (then earlier arrival, then lower slot).
// A tick's result is captured at the chain's end, then committed to the output
// register; the first tick after reset walks the chain twice when a slot holds
// work (time jump to earliest arrival). The chain length sets the rate.
// s_ready is high only between ticks; loads are taken back to back.
// A result waits in the output register while m_ready is low; the next tick
// may be accepted and scanned meanwhile, and commits once the register frees.
// Reset clears all slots as not loaded, the clock to zero and the run state.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler import srtf_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_kind,
    input  wire logic [PID_BITS-1:0]      s_process_id,
    input  wire logic [OUT_TIME_BITS-1:0] s_arrival_time,
    input  wire logic [REM_BITS-1:0]      s_burst_time,

    output logic      m_valid,
    input  wire logic m_ready,
    output logic [OUT_TIME_BITS-1:0] m_tick_time,
    output logic [PID_BITS-1:0]      m_running_id,
    output logic      m_idle,
    output logic      m_switched,
    output logic      m_first_run,
    output logic      m_finished,
    output logic      m_all_done
);

    cmd_t  cmd;
    time_t now_time;
    tok_t  chain [MAX_JOBS+1];

    srtf_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_process_id   (s_process_id),
        .s_arrival_time (s_arrival_time),
        .s_burst_time   (s_burst_time),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tick_time    (m_tick_time),
        .m_running_id   (m_running_id),
        .m_idle         (m_idle),
        .m_switched     (m_switched),
        .m_first_run    (m_first_run),
        .m_finished     (m_finished),
        .m_all_done     (m_all_done),
        .cmd            (cmd),
        .now_time       (now_time),
        .tok_first      (chain[0]),
        .tok_last       (chain[MAX_JOBS])
    );

    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        srtf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .slot_idx (SLOT_BITS'(i)),
            .now_time (now_time),
            .cmd      (cmd),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

endmodule
`default_nettype wire

FILE: design/srtf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks of the SRTF scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module srtf_checker import srtf_pkg::*; (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic s_kind,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_idle,
    input wire logic m_switched,
    input wire logic m_first_run,
    input wire logic m_finished
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_idle_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_idle |-> !m_switched && !m_first_run && !m_finished)
        else $error("idle result carries slot flags");

    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_LOAD) && !m_valid |=> !m_valid)
        else $error("load produced a result");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_TICK) |=> !s_ready)
        else $error("input taken during a scan");

endmodule

bind srtf_preemptive_scheduler srtf_checker u_srtf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_kind      (s_kind),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_idle      (m_idle),
    .m_switched  (m_switched),
    .m_first_run (m_first_run),
    .m_finished  (m_finished)
);
`default_nettype wire
